[src/pmst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared constants and types of the Prim spanning tree core.
// ----------------------------------------------------------------------------
package pmst_pkg;

	localparam int unsigned WeightW = 10;
	localparam int unsigned NodeW   = 5;
	localparam int unsigned TotalW  = 14;
	localparam logic [WeightW-1:0] NoEdge = 10'd999;

	// Controller to datapath commands.
	typedef struct packed {
		logic wr;         // store the accepted weight
		logic clr_pos;    // restart loading at the first entry
		logic seed_init;  // clear seed search
		logic seed_step;  // compare one matrix read
		logic tree_init;  // set nearest vertices, one row a cycle
		logic scan_init;  // clear least-cost search
		logic scan_step;  // compare one candidate
		logic add_pick;   // take the picked vertex into the tree
		logic upd_step;   // relax one row against the new vertex
		logic take_seed;  // latch seed as result
	} pmst_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic load_done;  // the beat being stored now goes to the last entry
		logic seed_none;
		logic scan_none;
	} pmst_sts_t;

endpackage : pmst_pkg
`default_nettype wire

[src/pmst_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_if
// Valid/ready channel carrying a payload of parameterised type.
// ----------------------------------------------------------------------------
interface pmst_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface : pmst_if
`default_nettype wire

[src/pmst_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_datapath
// Weight memory, nearest tree vertex array and search registers.
// Every search step does one memory read; the compare follows in the next cycle, on the registered read.
// ----------------------------------------------------------------------------
module pmst_datapath
	import pmst_pkg::*;
#(
	parameter int unsigned MAX_NODES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [NodeW-1:0]   cfg_n,
	input  wire logic [WeightW-1:0] in_w,
	input  wire pmst_cmd_t          cmd,
	output pmst_sts_t               sts,
	output logic                    step_last,
	output logic [NodeW-1:0]        res_from,
	output logic [NodeW-1:0]        res_to,
	output logic [WeightW-1:0]      res_cost,
	output logic [TotalW-1:0]       res_total,
	output logic [NodeW-1:0]        active_n
);
	localparam int unsigned IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int unsigned AW = 2 * IW;

	logic [WeightW-1:0] mem [1<<AW];
	logic [IW-1:0]      near_q [MAX_NODES];
	logic [MAX_NODES-1:0] member_q;

	logic [IW-1:0] row_q, col_q;     // load position
	logic [IW-1:0] i_q, j_q;         // search cursor
	logic [IW-1:0] ci_s1, cj_s1;     // cursor of the registered read
	logic [WeightW-1:0] rd_s1, rd2_s1;
	logic [WeightW-1:0] best_q;
	logic [IW-1:0] bi_q, bj_q;
	logic [IW-1:0] sk_q, sl_q;
	logic [TotalW-1:0] sum_q;
	logic [IW:0]   nm1;
	logic [IW-1:0] nlast;
	logic [WeightW-1:0] w_eff;
	logic [AW-1:0] ra, rb;
	logic          cur_last;
	logic [NodeW-1:0] n_c;
	logic [IW-1:0] pick_q;

	always_comb begin
		if (cfg_n < NodeW'(2))
			n_c = NodeW'(2);
		else if (32'(cfg_n) > MAX_NODES)
			n_c = NodeW'(MAX_NODES);
		else
			n_c = cfg_n;
	end
	assign active_n = n_c;
	assign nm1   = (IW+1)'(n_c - NodeW'(1));
	assign nlast = nm1[IW-1:0];

	assign w_eff = (in_w == '0 || in_w >= NoEdge || row_q == col_q) ? NoEdge : in_w;
	assign sts.load_done = row_q == nlast && col_q == nlast;
	assign cur_last = (i_q == nlast) && (cmd.seed_step ? (j_q == nlast) : 1'b1);
	assign step_last = cur_last;

	// Read address selection: seed sweeps the matrix, other passes walk rows.
	always_comb begin
		if (cmd.seed_step) begin
			ra = {i_q, j_q};
			rb = {i_q, j_q};
		end else if (cmd.tree_init) begin
			ra = {i_q, sl_q};
			rb = {i_q, sk_q};
		end else if (cmd.upd_step) begin
			ra = {i_q, near_q[i_q]};
			rb = {i_q, pick_q};
		end else begin
			ra = {i_q, near_q[i_q]};
			rb = {i_q, near_q[i_q]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr)
			mem[{row_q, col_q}] <= w_eff;
		rd_s1  <= mem[ra];
		rd2_s1 <= mem[rb];
	end

	logic seed_s1, tree_s1, scan_s1, upd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0; col_q <= '0; i_q <= '0; j_q <= '0;
			seed_s1 <= 1'b0; tree_s1 <= 1'b0;
			scan_s1 <= 1'b0; upd_s1 <= 1'b0;
			member_q <= '0; sum_q <= '0;
		end else begin
			if (cmd.clr_pos) begin
				row_q <= '0; col_q <= '0;
			end else if (cmd.wr) begin
				if (col_q == nlast) begin
					col_q <= '0;
					row_q <= sts.load_done ? '0 : row_q + IW'(1);
				end else begin
					col_q <= col_q + IW'(1);
				end
			end
			seed_s1 <= cmd.seed_step;
			tree_s1 <= cmd.tree_init;
			scan_s1 <= cmd.scan_step;
			upd_s1  <= cmd.upd_step;
			if (cmd.seed_init || cmd.scan_init) begin
				i_q <= '0; j_q <= '0;
			end else if (cmd.seed_step) begin
				// The sweep leaves the row cursor at zero for the set-up pass.
				if (j_q == nlast) begin
					j_q <= '0; i_q <= cur_last ? '0 : i_q + IW'(1);
				end else begin
					j_q <= j_q + IW'(1);
				end
			end else if (cmd.tree_init || cmd.scan_step || cmd.upd_step) begin
				i_q <= cur_last ? '0 : i_q + IW'(1);
			end
			if (cmd.take_seed) begin
				member_q <= (MAX_NODES'(1) << bi_q) | (MAX_NODES'(1) << bj_q);
				sum_q <= TotalW'(best_q);
			end
			if (cmd.add_pick) begin
				member_q[bi_q] <= 1'b1;
				sum_q <= sum_q + TotalW'(best_q);
			end
		end
	end

	// Search results and nearest array; payload only.
	always_ff @(posedge clk) begin
		ci_s1 <= i_q;
		cj_s1 <= j_q;
		if (cmd.seed_init || cmd.scan_init)
			best_q <= NoEdge;
		if (cmd.take_seed) begin
			sk_q <= bi_q;
			sl_q <= bj_q;
			res_from <= NodeW'(bi_q) + NodeW'(1);
			res_to   <= NodeW'(bj_q) + NodeW'(1);
			res_cost <= best_q;
			res_total <= TotalW'(best_q);
		end
		if (cmd.add_pick) begin
			pick_q <= bi_q;
			res_from <= NodeW'(bi_q) + NodeW'(1);
			res_to   <= NodeW'(near_q[bi_q]) + NodeW'(1);
			res_cost <= best_q;
			res_total <= sum_q + TotalW'(best_q);
		end
		if (seed_s1 && rd_s1 < best_q) begin
			best_q <= rd_s1; bi_q <= ci_s1; bj_q <= cj_s1;
		end
		if (scan_s1 && !member_q[ci_s1] && rd_s1 < best_q) begin
			best_q <= rd_s1; bi_q <= ci_s1;
		end
		if (tree_s1)
			near_q[ci_s1] <= (rd_s1 < rd2_s1) ? sl_q : sk_q;
		if (upd_s1 && !member_q[ci_s1] && rd_s1 > rd2_s1)
			near_q[ci_s1] <= pick_q;
	end

	assign sts.seed_none = best_q >= NoEdge;
	assign sts.scan_none = best_q >= NoEdge;
endmodule : pmst_datapath
`default_nettype wire

[src/pmst_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_ctrl
// Sequencer: loading, seed sweep, tree set-up, scan and update passes,
// result hand-off through the output register.
// ----------------------------------------------------------------------------
module pmst_ctrl
	import pmst_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             cfg_wr,
	input  wire logic             step_last,
	input  wire logic [NodeW-1:0] active_n,
	input  wire pmst_sts_t        sts,
	output pmst_cmd_t             cmd,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  out_disc,
	output logic                  out_last,
	output logic                  out_zero_edge,
	output logic                  out_zero_total
);
	typedef enum logic [3:0] {
		S_LOAD, S_SEED, S_SEED_END, S_SEED_CHK, S_TREE, S_TREE_END,
		S_SCAN, S_SCAN_END, S_SCAN_CHK, S_UPD, S_UPD_END, S_OUT
	} state_t;

	state_t state_q, next_q;
	logic [NodeW-1:0] edges_q;

	assign in_ready = (state_q == S_LOAD) && !cfg_wr;

	always_comb begin
		cmd = '0;
		cmd.wr = in_valid && in_ready;
		cmd.clr_pos = cfg_wr;
		unique case (state_q)
			S_LOAD:     cmd.seed_init = in_valid && in_ready && sts.load_done;
			S_SEED:     cmd.seed_step = 1'b1;
			S_SEED_CHK: cmd.take_seed = !sts.seed_none;
			S_TREE:     cmd.tree_init = 1'b1;
			S_TREE_END: cmd.scan_init = 1'b1;
			S_SCAN:     cmd.scan_step = 1'b1;
			S_SCAN_CHK: cmd.add_pick = !sts.scan_none;
			S_UPD:      cmd.upd_step = 1'b1;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD; next_q <= S_LOAD; edges_q <= '0;
			out_valid <= 1'b0; out_disc <= 1'b0; out_last <= 1'b0;
			out_zero_edge <= 1'b0; out_zero_total <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: if (cmd.seed_init) state_q <= S_SEED;
				S_SEED: if (step_last) state_q <= S_SEED_END;
				S_SEED_END: state_q <= S_SEED_CHK;
				S_SEED_CHK: begin
					out_valid <= 1'b1;
					state_q <= S_OUT;
					edges_q <= NodeW'(1);
					if (sts.seed_none) begin
						out_disc <= 1'b1; out_last <= 1'b1;
						out_zero_edge <= 1'b1; out_zero_total <= 1'b1;
						next_q <= S_LOAD;
					end else begin
						out_disc <= 1'b0; out_zero_edge <= 1'b0; out_zero_total <= 1'b0;
						out_last <= active_n == NodeW'(2);
						next_q <= (active_n == NodeW'(2)) ? S_LOAD : S_TREE;
					end
				end
				S_TREE: if (step_last) state_q <= S_TREE_END;
				S_TREE_END: state_q <= S_SCAN;
				S_SCAN: if (step_last) state_q <= S_SCAN_END;
				S_SCAN_END: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					out_valid <= 1'b1;
					state_q <= S_OUT;
					out_zero_total <= 1'b0;
					if (sts.scan_none) begin
						out_disc <= 1'b1; out_last <= 1'b1; out_zero_edge <= 1'b1;
						next_q <= S_LOAD;
					end else begin
						edges_q <= edges_q + NodeW'(1);
						out_disc <= 1'b0; out_zero_edge <= 1'b0;
						out_last <= (edges_q + NodeW'(1)) == (active_n - NodeW'(1));
						next_q <= ((edges_q + NodeW'(1)) == (active_n - NodeW'(1)))
							? S_LOAD : S_UPD;
					end
				end
				S_UPD: if (step_last) state_q <= S_UPD_END;
				S_UPD_END: begin
					state_q <= S_TREE_END;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= next_q;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule : pmst_ctrl
`default_nettype wire

[src/prim_minimum_spanning_tree_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_core
// Prim spanning tree over a streamed adjacency matrix.
//
//   channel   direction  payload
//   cfg       in         node_count (5 bits)
//   in        in         edge_weight (10 bits)
//   out       out        from_node, to_node, edge_cost, total_cost,
//                        disconnected, last
//
// Loading takes one beat per cycle while no cfg beat arrives, n*n beats. The
// run then does the seed sweep, a pass to set up the nearest array and, per
// added vertex, the scan and update passes (the last vertex skips its update
// pass); each pass reads the weight memory once a cycle. Each result waits
// in the output register until taken; the run holds meanwhile.
// No input beat is taken while a run is in progress. No clearing pass is needed.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_core
	import pmst_pkg::*;
#(
	parameter int unsigned MAX_NODES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	pmst_if.sink     cfg,
	pmst_if.sink     in,
	pmst_if.source   out
);
	logic [NodeW-1:0] node_count_q;
	pmst_cmd_t cmd;
	pmst_sts_t sts;
	logic step_last;
	logic [NodeW-1:0] active_n, r_from, r_to;
	logic [WeightW-1:0] r_cost;
	logic [TotalW-1:0] r_total;
	logic o_disc, o_last, z_edge, z_total;
	logic cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			node_count_q <= NodeW'(16);
		else if (cfg_wr)
			node_count_q <= cfg.data[NodeW-1:0];
	end

	pmst_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in.valid), .in_ready(in.ready), .cfg_wr,
		.step_last, .active_n, .sts, .cmd,
		.out_valid(out.valid), .out_ready(out.ready),
		.out_disc(o_disc), .out_last(o_last),
		.out_zero_edge(z_edge), .out_zero_total(z_total)
	);

	pmst_datapath #(.MAX_NODES(MAX_NODES)) u_dp (
		.clk, .arst_n, .cfg_n(node_count_q), .in_w(in.data[WeightW-1:0]),
		.cmd, .sts, .step_last,
		.res_from(r_from), .res_to(r_to), .res_cost(r_cost), .res_total(r_total),
		.active_n
	);

	assign out.data.from_node    = z_edge ? '0 : r_from;
	assign out.data.to_node      = z_edge ? '0 : r_to;
	assign out.data.edge_cost    = z_edge ? '0 : r_cost;
	assign out.data.total_cost   = z_total ? '0 : r_total;
	assign out.data.disconnected = o_disc;
	assign out.data.last         = o_last;
endmodule : prim_minimum_spanning_tree_core
`default_nettype wire
